// ===== rtl/csw_pkg.sv =====
`default_nettype none

package csw_pkg;

  // datapath widths
  localparam int GUARD_BITS = 8;
  localparam int XW         = 43;  // cordic x/y: 32 input bits, 8 guard bits, growth and sign

  // inverse cordic gain, unsigned 0.32
  localparam logic [31:0] INV_GAIN = 32'd2608131496;

  // angle thresholds in turns (2^32 = 2pi), one unit of t is 2^29
  localparam logic [31:0] T_ONE   = 32'h2000_0000;
  localparam logic [31:0] T_THREE = 32'h6000_0000;
  localparam logic [31:0] T_FIVE  = 32'hA000_0000;
  localparam logic [31:0] T_SEVEN = 32'hE000_0000;

  // corner positions as signed offsets
  localparam logic signed [33:0] CORNER_2 = 34'sh0_4000_0000;
  localparam logic signed [33:0] CORNER_4 = 34'sh0_8000_0000;
  localparam logic signed [33:0] CORNER_6 = 34'sh0_C000_0000;
  localparam logic signed [33:0] CORNER_8 = 34'sh1_0000_0000;

  // side of the square that the angle lands on
  typedef enum logic [2:0] {
    SEG_RIGHT_LOW,
    SEG_TOP,
    SEG_LEFT,
    SEG_BOTTOM,
    SEG_RIGHT_HIGH
  } csw_seg_t;

  // item moving down the cordic chain
  typedef struct packed {
    logic                 valid;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [31:0]          z;
    logic signed [31:0]   acc_x;
    logic signed [31:0]   acc_y;
  } csw_cord_t;

  // finished result
  typedef struct packed {
    logic               valid;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
  } csw_res_t;

  // arctan(2^-k) in turns
  function automatic logic [31:0] csw_atan(input logic [4:0] k);
    logic [31:0] a;
    unique case (k)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      5'd31: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/csw_if.sv =====
`default_nettype none

// input point channel
interface csw_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] tx;
  logic signed [31:0] ty;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  modport source (output valid, tx, ty, acc_x, acc_y, input ready);
  modport sink   (input valid, tx, ty, acc_x, acc_y, output ready);
endinterface

// result channel
interface csw_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  modport source (output valid, out_x, out_y, input ready);
  modport sink   (input valid, out_x, out_y, output ready);
endinterface

// weight register write channel
interface csw_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/circle_to_square_warp.sv =====
`default_nettype none

// Square-perimeter warp of a point, signed fixed point with FRAC_BITS fraction bits.
// Each point (tx, ty) is turned into radius and angle by a row of CORDIC_STAGES cordic
// cells, one iteration per cell, then mapped onto a square of half-side equal to the
// radius, scaled by the weight register and added with saturation to (acc_x, acc_y).
// One point is taken per clock cycle; a result passes through one input register, the
// cordic row, eight post-processing stages and the output register. The output
// register is backed by a one-entry skid stage, so the input keeps taking points
// while a result waits; the input stalls only once the skid stage is also holding a
// result. Write the weight only while no point is in flight.
module circle_to_square_warp #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 24
) (
  input  wire logic  clk,
  input  wire logic  rst,
  csw_cfg_if.sink    cfg,
  csw_in_if.sink     point,
  csw_out_if.source  result
);

  localparam int XW = csw_pkg::XW;

  logic signed [31:0] weight;
  logic               skid_full;
  logic               pipe_en;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  csw_pkg::csw_cord_t prep;
  csw_pkg::csw_cord_t chain [CORDIC_STAGES+1];
  csw_pkg::csw_res_t  post_res;

  // weight register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= 32'sd65536;
    end else if (cfg.valid) begin
      weight <= $signed(cfg.data);
    end
  end

  assign pipe_en     = !skid_full;
  assign point.ready = pipe_en;

  // add guard bits, fold the left half plane over by pi
  always_comb begin
    x0         = {{3{point.tx[31]}}, point.tx, 8'b0};
    y0         = {{3{point.ty[31]}}, point.ty, 8'b0};
    prep.valid = point.valid;
    prep.acc_x = point.acc_x;
    prep.acc_y = point.acc_y;
    if (point.tx[31]) begin
      prep.x = -x0;
      prep.y = -y0;
      prep.z = 32'h8000_0000;
    end else begin
      prep.x = x0;
      prep.y = y0;
      prep.z = 32'h0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (pipe_en) begin
      chain[0] <= prep;
    end
  end

  // row of cordic cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    csw_cordic_cell #(.K(i)) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (pipe_en),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  // radius, side, weight and accumulate
  csw_post #(.FRAC_BITS(FRAC_BITS)) u_post (
    .clk    (clk),
    .rst    (rst),
    .en     (pipe_en),
    .weight (weight),
    .cord   (chain[CORDIC_STAGES]),
    .res    (post_res)
  );

  // output register with skid stage
  csw_skid u_skid (
    .clk  (clk),
    .rst  (rst),
    .d    (post_res),
    .res  (result),
    .full (skid_full)
  );

`ifndef SYNTHESIS
  // a held skid entry means the output register is full too
  ap_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> result.valid)
    else $error("skid stage full while output register empty");

  // a weight transfer lands in the register
  ap_weight_write: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready |=> weight == $signed($past(cfg.data)))
    else $error("weight register missed a transfer");

  // vectoring keeps x non-negative down the whole row
  ap_cordic_x_pos: assert property (@(posedge clk) disable iff (rst)
    chain[CORDIC_STAGES].valid |-> !chain[CORDIC_STAGES].x[XW-1])
    else $error("cordic x went negative");
`endif

endmodule

`default_nettype wire

// ===== rtl/csw_cordic_cell.sv =====
`default_nettype none

module csw_cordic_cell #(
  parameter int K = 0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire csw_pkg::csw_cord_t d,
  output csw_pkg::csw_cord_t      q
);

  localparam logic [31:0] ANGLE = csw_pkg::csw_atan(5'(K));

  logic signed [csw_pkg::XW-1:0] dx;
  logic signed [csw_pkg::XW-1:0] dy;
  csw_pkg::csw_cord_t            q_next;

  // one vectoring step: drive y toward zero, collect the angle
  always_comb begin
    dx     = d.y >>> K;
    dy     = d.x >>> K;
    q_next = d;
    if (!d.y[csw_pkg::XW-1]) begin
      q_next.x = d.x + dx;
      q_next.y = d.y - dy;
      q_next.z = d.z + ANGLE;
    end else begin
      q_next.x = d.x - dx;
      q_next.y = d.y + dy;
      q_next.z = d.z - ANGLE;
    end
  end

  // hand the item to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csw_post.sv =====
`default_nettype none

module csw_post #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic signed [31:0] weight,
  input  wire csw_pkg::csw_cord_t cord,
  output csw_pkg::csw_res_t       res
);

  localparam int PW = 66;             // weight times side coordinate
  localparam int DW = PW - FRAC_BITS; // weighted coordinate after rounding
  localparam int SW = DW + 1;         // accumulator sum
  localparam int NS = 8;              // stages in this unit
  localparam logic signed [PW-1:0] RND = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  // stage valid bits and accumulator shift line
  logic [NS-1:0]      vld;
  logic signed [31:0] ax_p [NS-1];
  logic signed [31:0] ay_p [NS-1];

  // stage 1: split gain multiply
  logic [63:0] lo1;
  logic [41:0] hi1;
  logic [31:0] z1;

  // stage 2: scaled radius with guard bits, side decode
  logic [64:0]       lo_sum;
  logic [42:0]       u_next;
  logic [42:0]       u2;
  logic signed [33:0] c_next;
  logic [29:0]       mag_next;
  csw_pkg::csw_seg_t seg_next;
  csw_pkg::csw_seg_t seg2;
  logic              neg2;
  logic [29:0]       mag2;

  // stage 3: radius
  logic [43:0]       s_sum;
  logic [31:0]       s3;
  csw_pkg::csw_seg_t seg3;
  logic              neg3;
  logic [29:0]       mag3;

  // stage 4: radius times offset
  logic [61:0]       prod4;
  logic [31:0]       s4;
  csw_pkg::csw_seg_t seg4;
  logic              neg4;

  // stage 5: warped point
  logic [62:0]        q_sum;
  logic [32:0]        qm;
  logic signed [33:0] qs;
  logic signed [33:0] sv;
  logic signed [33:0] vx_next;
  logic signed [33:0] vy_next;
  logic signed [33:0] vx5;
  logic signed [33:0] vy5;

  // stage 6 and 7: weighting
  logic signed [PW-1:0] wx6;
  logic signed [PW-1:0] wy6;
  logic signed [PW-1:0] rx;
  logic signed [PW-1:0] ry;
  logic signed [DW-1:0] dx7;
  logic signed [DW-1:0] dy7;

  // stage 8: saturated sum
  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;
  logic signed [31:0]   ox;
  logic signed [31:0]   oy;

  function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
    logic [SW-32:0] top;
    logic [31:0]    r;
    top = v[SW-1:31];
    if (top == '0 || top == '1) begin
      r = v[31:0];
    end else if (v[SW-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  // gain removal and side selection
  always_comb begin
    lo_sum = {1'b0, lo1} + 65'h0_8000_0000;
    u_next = {1'b0, hi1} + {10'b0, lo_sum[64:32]};
    priority if (z1 <= csw_pkg::T_ONE) begin
      seg_next = csw_pkg::SEG_RIGHT_LOW;
      c_next   = $signed({2'b00, z1});
    end else if (z1 <= csw_pkg::T_THREE) begin
      seg_next = csw_pkg::SEG_TOP;
      c_next   = csw_pkg::CORNER_2 - $signed({2'b00, z1});
    end else if (z1 <= csw_pkg::T_FIVE) begin
      seg_next = csw_pkg::SEG_LEFT;
      c_next   = csw_pkg::CORNER_4 - $signed({2'b00, z1});
    end else if (z1 <= csw_pkg::T_SEVEN) begin
      seg_next = csw_pkg::SEG_BOTTOM;
      c_next   = $signed({2'b00, z1}) - csw_pkg::CORNER_6;
    end else begin
      seg_next = csw_pkg::SEG_RIGHT_HIGH;
      c_next   = $signed({2'b00, z1}) - csw_pkg::CORNER_8;
    end
    mag_next = c_next[33] ? 30'(-c_next) : c_next[29:0];
    s_sum    = {1'b0, u2} + 44'd128;
  end

  // side coordinate with rounding away from zero, then the point on the square
  always_comb begin
    q_sum = {1'b0, prod4} + 63'h1000_0000;
    qm    = q_sum[61:29];
    qs    = neg4 ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    sv    = $signed({2'b00, s4});
    unique case (seg4)
      csw_pkg::SEG_RIGHT_LOW, csw_pkg::SEG_RIGHT_HIGH: begin
        vx_next = sv;
        vy_next = qs;
      end
      csw_pkg::SEG_TOP: begin
        vx_next = qs;
        vy_next = sv;
      end
      csw_pkg::SEG_LEFT: begin
        vx_next = -sv;
        vy_next = qs;
      end
      csw_pkg::SEG_BOTTOM: begin
        vx_next = qs;
        vy_next = -sv;
      end
      default: begin
        vx_next = sv;
        vy_next = qs;
      end
    endcase
  end

  // weight rounding and accumulate
  always_comb begin
    rx    = wx6 + RND;
    ry    = wy6 + RND;
    sum_x = SW'(ax_p[NS-2]) + SW'(dx7);
    sum_y = SW'(ay_p[NS-2]) + SW'(dy7);
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], cord.valid};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      ax_p[0] <= cord.acc_x;
      ay_p[0] <= cord.acc_y;
      for (int i = 1; i < NS - 1; i++) begin
        ax_p[i] <= ax_p[i-1];
        ay_p[i] <= ay_p[i-1];
      end
      lo1   <= 64'(cord.x[31:0]) * 64'(csw_pkg::INV_GAIN);
      hi1   <= 42'(cord.x[41:32]) * 42'(csw_pkg::INV_GAIN);
      z1    <= cord.z;
      u2    <= u_next;
      seg2  <= seg_next;
      neg2  <= c_next[33];
      mag2  <= mag_next;
      s3    <= s_sum[39:8];
      seg3  <= seg2;
      neg3  <= neg2;
      mag3  <= mag2;
      prod4 <= 62'(s3) * 62'(mag3);
      s4    <= s3;
      seg4  <= seg3;
      neg4  <= neg3;
      vx5   <= vx_next;
      vy5   <= vy_next;
      wx6   <= weight * vx5;
      wy6   <= weight * vy5;
      dx7   <= DW'(rx >>> FRAC_BITS);
      dy7   <= DW'(ry >>> FRAC_BITS);
      ox    <= sat32(sum_x);
      oy    <= sat32(sum_y);
    end
  end

  assign res.valid = vld[NS-1];
  assign res.out_x = ox;
  assign res.out_y = oy;

endmodule

`default_nettype wire

// ===== rtl/csw_skid.sv =====
`default_nettype none

module csw_skid (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire csw_pkg::csw_res_t d,
  csw_out_if.source              res,
  output logic                   full
);

  csw_pkg::csw_res_t oreg;
  csw_pkg::csw_res_t sreg;
  logic              take;
  logic              arrive;

  // the pipeline only moves while the skid stage is empty
  assign arrive = d.valid && !sreg.valid;
  assign take   = !oreg.valid || res.ready;

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      oreg.valid <= 1'b0;
      sreg.valid <= 1'b0;
    end else if (take) begin
      if (sreg.valid) begin
        oreg       <= sreg;
        sreg.valid <= 1'b0;
      end else begin
        oreg <= d;
      end
    end else if (arrive) begin
      sreg <= d;
    end
  end

  assign res.valid = oreg.valid;
  assign res.out_x = oreg.out_x;
  assign res.out_y = oreg.out_y;
  assign full      = sreg.valid;

endmodule

`default_nettype wire
